// ----- src/tilt_angle_with_zero_reference_defines.svh -----
// Assertion macros for the checker file of the tilt angle block.
`ifndef TILT_ANGLE_WITH_ZERO_REFERENCE_DEFINES_SVH
`define TILT_ANGLE_WITH_ZERO_REFERENCE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define TAWZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tilt angle checker: next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define TAWZ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tilt angle checker: same-cycle property failed");

// Consequent must hold in the cycle after reset is seen low.
`define TAWZ_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("tilt angle checker: reset property failed");

`endif

// ----- src/tawz_pkg.sv -----
// Types and constants of the tilt angle block.
package tawz_pkg;

    localparam int SAMPLE_IN_W  = 16;
    localparam int SCALE_BITS   = 30;
    localparam int VEC_W        = 34;
    localparam int ANG_W        = 26;
    localparam int ANGLE_FRAC   = 16;
    localparam int ABS_W        = 9;
    localparam int REL_W        = 10;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_IDX_W   = 5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ZERO   = 1'b1;

    localparam logic [STEP_IDX_W-1:0] LAST_STEP = STEP_IDX_W'(CORDIC_STEPS - 1);

    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;

    // atan(2^-i) in units of 2^-16 degree.
    localparam logic signed [ANG_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
    };

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ITER = 3'b010,
        ST_DONE = 3'b100
    } t_eng_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

// ----- src/tilt_angle_with_zero_reference.sv -----
// Tilt angle block: atan2 of X and Z in whole degrees, absolute and zero-relative.
//
// Input channel: i_valid, o_stall, i_operation, i_x_sample, i_z_sample.
// An item is taken at a clock edge with i_valid high and o_stall low.
// A sample item (operation 0) yields one result; a zero item (operation 1)
// copies the last angle into the zero reference at its acceptance edge and yields none.
// Output channel: o_valid, i_stall, o_absolute_angle, o_relative_angle.
// A result is taken at an edge with o_valid high and i_stall low.
// A sample is loaded at its acceptance edge, then takes at most 20 CORDIC steps
// on one shared shift-and-add unit before it moves into the output register;
// o_valid rises and the block turns idle at that edge, and no new item is
// taken while a sample is still in the CORDIC unit.
// Steps end early when the vector lands on the axis, and a zero Z reading
// skips the steps entirely.
// While a result stalls in the output register the block still takes an
// item; a finished angle waits in the CORDIC unit until the register frees.
// Synchronous active-low reset clears the last angle, the zero reference
// and all valid state.
module tilt_angle_with_zero_reference
    import tawz_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic signed [SAMPLE_IN_W-1:0] i_x_sample,
    input  logic signed [SAMPLE_IN_W-1:0] i_z_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ABS_W-1:0]       o_absolute_angle,
    output logic signed [REL_W-1:0]       o_relative_angle
);

    t_eng_ctrl               eng_ctrl;
    t_eng_stat               eng_stat;
    logic signed [ABS_W-1:0] eng_angle;
    logic                    in_acc;
    logic                    load_out;

    logic                    r_out_valid;
    logic signed [ABS_W-1:0] r_abs;
    logic signed [REL_W-1:0] r_rel;
    logic signed [ABS_W-1:0] r_last_angle;
    logic signed [ABS_W-1:0] r_zero_ref;

    assign o_stall  = !eng_stat.idle;
    assign in_acc   = i_valid && eng_stat.idle;
    assign load_out = eng_stat.done && (!r_out_valid || !i_stall);

    assign eng_ctrl.start = in_acc && (i_operation == OP_SAMPLE);
    assign eng_ctrl.take  = load_out;

    tawz_cordic #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (eng_ctrl),
        .i_x     (i_x_sample),
        .i_z     (i_z_sample),
        .o_stat  (eng_stat),
        .o_angle (eng_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_angle <= '0;
            r_zero_ref   <= '0;
        end else begin
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_last_angle <= eng_angle;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && (i_operation == OP_ZERO)) begin
                r_zero_ref <= r_last_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_abs <= eng_angle;
            r_rel <= REL_W'(eng_angle) - REL_W'(r_zero_ref);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_absolute_angle = r_abs;
    assign o_relative_angle = r_rel;

endmodule

// ----- src/tawz_cordic.sv -----
// Iterative vectoring CORDIC that turns an X/Z pair into whole degrees.
module tawz_cordic
    import tawz_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_eng_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_IN_W-1:0] i_x,
    input  logic signed [SAMPLE_IN_W-1:0] i_z,
    output t_eng_stat                     o_stat,
    output logic signed [ABS_W-1:0]       o_angle
);

    t_eng_state                 r_state, n_state;
    logic signed [VEC_W-1:0]    r_u, n_u;
    logic signed [VEC_W-1:0]    r_v, n_v;
    logic signed [ANG_W-1:0]    r_ang, n_ang;
    logic [STEP_IDX_W-1:0]      r_i, n_i;

    logic signed [SAMPLE_WIDTH-1:0] x_low;
    logic signed [SAMPLE_WIDTH-1:0] z_low;
    logic signed [VEC_W-1:0]        xs;
    logic signed [VEC_W-1:0]        zs;
    logic signed [VEC_W-1:0]        du;
    logic signed [VEC_W-1:0]        dv;
    logic [ANG_W-1:0]               ang_mag;
    logic [ANG_W-ANGLE_FRAC-1:0]    deg_mag;
    logic [ANG_W-ANGLE_FRAC-1:0]    deg_signed;

    assign x_low = i_x[SAMPLE_WIDTH-1:0];
    assign z_low = i_z[SAMPLE_WIDTH-1:0];
    assign xs    = VEC_W'(x_low) <<< (SCALE_BITS - SAMPLE_WIDTH);
    assign zs    = VEC_W'(z_low) <<< (SCALE_BITS - SAMPLE_WIDTH);

    assign du = r_v >>> r_i;
    assign dv = r_u >>> r_i;

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_v     = r_v;
        n_ang   = r_ang;
        n_i     = r_i;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_i = '0;
                    if (zs == '0) begin
                        n_u = zs;
                        n_v = xs;
                        if (xs == '0) begin
                            n_ang = '0;
                        end else if (xs[VEC_W-1]) begin
                            n_ang = -DEG90;
                        end else begin
                            n_ang = DEG90;
                        end
                        n_state = ST_DONE;
                    end else if (zs[VEC_W-1]) begin
                        n_u     = -zs;
                        n_v     = -xs;
                        n_ang   = xs[VEC_W-1] ? -DEG180 : DEG180;
                        n_state = ST_ITER;
                    end else begin
                        n_u     = zs;
                        n_v     = xs;
                        n_ang   = '0;
                        n_state = ST_ITER;
                    end
                end
            end
            ST_ITER: begin
                if (r_v == '0) begin
                    n_state = ST_DONE;
                end else begin
                    if (r_v[VEC_W-1]) begin
                        n_u   = r_u - du;
                        n_v   = r_v + dv;
                        n_ang = r_ang - STEP_ANGLE[r_i];
                    end else begin
                        n_u   = r_u + du;
                        n_v   = r_v - dv;
                        n_ang = r_ang + STEP_ANGLE[r_i];
                    end
                    if (r_i == LAST_STEP) begin
                        n_state = ST_DONE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_ctrl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_ang <= n_ang;
        r_i   <= n_i;
    end

    // Truncate toward zero to whole degrees.
    assign ang_mag    = r_ang[ANG_W-1] ? ANG_W'(-r_ang) : ANG_W'(r_ang);
    assign deg_mag    = ang_mag[ANG_W-1:ANGLE_FRAC];
    assign deg_signed = r_ang[ANG_W-1] ? -deg_mag : deg_mag;
    assign o_angle    = deg_signed[ABS_W-1:0];

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);

endmodule

// ----- src/tawz_checker.sv -----
// Port-level checker for the tilt angle block and its bind.
`include "tilt_angle_with_zero_reference_defines.svh"

module tawz_checker
    import tawz_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_operation,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [ABS_W-1:0]       o_absolute_angle,
    input logic signed [REL_W-1:0]       o_relative_angle
);

    `TAWZ_ASSERT_RESET(a_reset_clears_valid, !o_valid)

    `TAWZ_ASSERT_NEXT(a_stalled_result_holds, o_valid && i_stall,
        o_valid && $stable(o_absolute_angle) && $stable(o_relative_angle))

    `TAWZ_ASSERT_NEXT(a_sample_makes_busy,
        i_valid && !o_stall && (i_operation == OP_SAMPLE), o_stall)

    `TAWZ_ASSERT_NOW(a_angle_in_range, o_valid,
        (o_absolute_angle >= -9'sd180) && (o_absolute_angle <= 9'sd180))

endmodule

bind tilt_angle_with_zero_reference tawz_checker u_tawz_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_operation      (i_operation),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_absolute_angle (o_absolute_angle),
    .o_relative_angle (o_relative_angle)
);
